// ===== rtl/core/tsq_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_pkg: shared types and constants of the sleep queue timer
// Request and status codes, register map, cell commands, reset values.
// ----------------------------------------------------------------------------
package tsq_pkg;

   localparam int QUEUE_DEPTH_DEFAULT  = 16;
   localparam int TASK_ID_BITS_DEFAULT = 8;

   localparam int TIME_BITS   = 64;
   localparam int RELOAD_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;
   localparam int CSR_DATA_BITS = 64;

   localparam logic [29:0] PERIOD_NS_RESET     = 30'd1000000;
   localparam logic [31:0] PERIOD_COUNTS_RESET = 32'd62500;
   localparam logic [RELOAD_BITS-1:0] RELOAD_MAX = 32'h7FFF_FFFF;

   typedef enum logic [1:0] {
      REQ_START     = 2'd0,
      REQ_SCHEDULE  = 2'd1,
      REQ_CANCEL    = 2'd2,
      REQ_TIMER_IRQ = 2'd3
   } req_type_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_NOT_FOUND = 2'd1,
      ST_FULL      = 2'd2
   } status_type;

   typedef enum logic {
      KIND_WAKE  = 1'b0,
      KIND_FINAL = 1'b1
   } kind_type;

   typedef enum logic [1:0] {
      CSR_PERIOD_NS     = 2'd0,
      CSR_PERIOD_COUNTS = 2'd1,
      CSR_MULT          = 2'd2,
      CSR_SHIFT         = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [29:0] period_ns;
      logic [31:0] period_counts;
      logic [63:0] mult;
      logic [5:0]  shift;
   } cfg_type;

   typedef enum logic [1:0] {
      CELL_HOLD   = 2'd0,
      CELL_INSERT = 2'd1,
      CELL_SHIFT  = 2'd2
   } cell_op_type;

   typedef struct packed {
      cell_op_type          op;
      logic [TIME_BITS-1:0] key;
   } cell_cmd_type;

endpackage
`default_nettype wire

// ===== rtl/core/tsq_req_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_req_if: request channel
// Valid/ready channel carrying one queue request per transfer.
// ----------------------------------------------------------------------------
interface tsq_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [7:0]  task_id;
   logic [63:0] wake_time;
   logic [63:0] now_ns;

   modport source (output valid, req_type, task_id, wake_time, now_ns, input ready);
   modport sink   (input valid, req_type, task_id, wake_time, now_ns, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsq_rsp_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_rsp_if: result channel
// Valid/ready channel carrying one wake or final result per transfer.
// ----------------------------------------------------------------------------
interface tsq_rsp_if;
   logic        valid;
   logic        ready;
   logic        result_kind;
   logic [7:0]  woken_task;
   logic        reload_valid;
   logic [31:0] reload_counts;
   logic        tick_passed;
   logic [1:0]  status;
   logic        last;

   modport source (output valid, result_kind, woken_task, reload_valid, reload_counts,
                   tick_passed, status, last, input ready);
   modport sink   (input valid, result_kind, woken_task, reload_valid, reload_counts,
                   tick_passed, status, last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/tsq_csr.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_csr: configuration registers
// APB-style register file: tick period, reload period, ns-to-count scaling.
// ----------------------------------------------------------------------------
module tsq_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               psel,
   input  wire logic                               penable,
   input  wire logic                               pwrite,
   input  wire logic [tsq_pkg::CSR_ADDR_BITS-1:0]  paddr,
   input  wire logic [tsq_pkg::CSR_DATA_BITS-1:0]  pwdata,
   output logic      [tsq_pkg::CSR_DATA_BITS-1:0]  prdata,
   output logic                                    pready,
   output tsq_pkg::cfg_type                        cfg
);
   import tsq_pkg::*;

   cfg_type       cfg_ff;
   csr_index_type idx;
   logic          wr;

   assign idx    = csr_index_type'(paddr[4:3]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;
   assign cfg    = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.period_ns     <= PERIOD_NS_RESET;
         cfg_ff.period_counts <= PERIOD_COUNTS_RESET;
         cfg_ff.mult          <= '0;
         cfg_ff.shift         <= '0;
      end else if (wr) begin
         case (idx)
            CSR_PERIOD_NS:     cfg_ff.period_ns     <= pwdata[29:0];
            CSR_PERIOD_COUNTS: cfg_ff.period_counts <= pwdata[31:0];
            CSR_MULT:          cfg_ff.mult          <= pwdata[63:0];
            CSR_SHIFT:         cfg_ff.shift         <= pwdata[5:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (idx)
         CSR_PERIOD_NS:     prdata = {34'b0, cfg_ff.period_ns};
         CSR_PERIOD_COUNTS: prdata = {32'b0, cfg_ff.period_counts};
         CSR_MULT:          prdata = cfg_ff.mult;
         CSR_SHIFT:         prdata = {58'b0, cfg_ff.shift};
         default:           prdata = '0;
      endcase
   end

endmodule
`default_nettype wire

// ===== rtl/core/tsq_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_cell: one sleep queue slot
// Holds one deadline and task id; inserts in order or shifts toward the head.
// ----------------------------------------------------------------------------
module tsq_cell #(
   parameter int QUEUE_DEPTH  = tsq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TASK_ID_BITS = tsq_pkg::TASK_ID_BITS_DEFAULT,
   parameter int CELL_INDEX   = 0,
   localparam int CNT_BITS    = $clog2(QUEUE_DEPTH + 1),
   localparam int IDX_BITS    = $clog2(QUEUE_DEPTH)
) (
   input  wire logic                              clock,
   input  wire tsq_pkg::cell_cmd_type             cmd,
   input  wire logic [TASK_ID_BITS-1:0]           cmd_task,
   input  wire logic [CNT_BITS-1:0]               count,
   input  wire logic [IDX_BITS-1:0]               pos,
   input  wire logic                              prev_gt,
   input  wire logic [tsq_pkg::TIME_BITS-1:0]     prev_deadline,
   input  wire logic [TASK_ID_BITS-1:0]           prev_task,
   input  wire logic [tsq_pkg::TIME_BITS-1:0]     next_deadline,
   input  wire logic [TASK_ID_BITS-1:0]           next_task,
   output logic                                   gt,
   output logic      [tsq_pkg::TIME_BITS-1:0]     deadline,
   output logic      [TASK_ID_BITS-1:0]           entry_task,
   output logic                                   hit
);
   import tsq_pkg::*;

   logic [TIME_BITS-1:0]    deadline_ff, deadline_in;
   logic [TASK_ID_BITS-1:0] task_ff, task_in;
   logic                    occupied;

   assign occupied   = CNT_BITS'(CELL_INDEX) < count;
   assign gt         = !occupied || (deadline_ff > cmd.key);
   assign hit        = (pos == IDX_BITS'(CELL_INDEX)) && (task_ff == cmd_task);
   assign deadline   = deadline_ff;
   assign entry_task = task_ff;

   always_comb begin
      deadline_in = deadline_ff;
      task_in     = task_ff;
      case (cmd.op)
         CELL_INSERT: begin
            if (gt) begin
               if (prev_gt) begin
                  deadline_in = prev_deadline;
                  task_in     = prev_task;
               end else begin
                  deadline_in = cmd.key;
                  task_in     = cmd_task;
               end
            end
         end
         CELL_SHIFT: begin
            if (IDX_BITS'(CELL_INDEX) >= pos) begin
               deadline_in = next_deadline;
               task_in     = next_task;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      deadline_ff <= deadline_in;
      task_ff     <= task_in;
   end

endmodule
`default_nettype wire

// ===== rtl/core/tsq_conv.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// tsq_conv: nanosecond to counter conversion
// Delta to target, 64x64 multiply in four 32x32 partial products, shift, clamp.
// ----------------------------------------------------------------------------
module tsq_conv (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [tsq_pkg::TIME_BITS-1:0]       target,
   input  wire logic [tsq_pkg::TIME_BITS-1:0]       now,
   input  wire logic [63:0]                         mult,
   input  wire logic [5:0]                          shift,
   output logic                                     done,
   output logic      [tsq_pkg::RELOAD_BITS-1:0]     counts
);
   import tsq_pkg::*;

   typedef enum logic [2:0] {
      C_IDLE, C_MUL0, C_MUL1, C_MUL2, C_MUL3, C_ACC, C_SHIFT, C_CLAMP
   } conv_state_type;

   conv_state_type         state_ff, state_in;
   logic                   done_ff, done_in;
   logic [TIME_BITS-1:0]   delta_ff, delta_in;
   logic [63:0]            pp_ff, pp_in;
   logic [127:0]           acc_ff, acc_in;
   logic [127:0]           sh_ff, sh_in;
   logic [RELOAD_BITS-1:0] counts_ff, counts_in;
   logic [31:0]            op_a, op_b;
   logic [6:0]             acc_off;

   assign done   = done_ff;
   assign counts = counts_ff;

   always_comb begin
      state_in  = state_ff;
      done_in   = 1'b0;
      delta_in  = delta_ff;
      pp_in     = pp_ff;
      acc_in    = acc_ff;
      sh_in     = sh_ff;
      counts_in = counts_ff;
      op_a      = delta_ff[31:0];
      op_b      = mult[31:0];
      acc_off   = 7'd0;
      case (state_ff)
         C_IDLE: begin
            if (start) begin
               delta_in = (target > now) ? target - now : '0;
               acc_in   = '0;
               state_in = C_MUL0;
            end
         end
         C_MUL0: begin
            pp_in    = 64'(op_a) * 64'(op_b);
            state_in = C_MUL1;
         end
         C_MUL1: begin
            op_b     = mult[63:32];
            pp_in    = 64'(op_a) * 64'(op_b);
            acc_in   = acc_ff + ({64'b0, pp_ff} << acc_off);
            state_in = C_MUL2;
         end
         C_MUL2: begin
            op_a     = delta_ff[63:32];
            pp_in    = 64'(op_a) * 64'(op_b);
            acc_off  = 7'd32;
            acc_in   = acc_ff + ({64'b0, pp_ff} << acc_off);
            state_in = C_MUL3;
         end
         C_MUL3: begin
            op_a     = delta_ff[63:32];
            op_b     = mult[63:32];
            pp_in    = 64'(op_a) * 64'(op_b);
            acc_off  = 7'd32;
            acc_in   = acc_ff + ({64'b0, pp_ff} << acc_off);
            state_in = C_ACC;
         end
         C_ACC: begin
            acc_off  = 7'd64;
            acc_in   = acc_ff + ({64'b0, pp_ff} << acc_off);
            state_in = C_SHIFT;
         end
         C_SHIFT: begin
            sh_in    = acc_ff >> shift;
            state_in = C_CLAMP;
         end
         C_CLAMP: begin
            if (|sh_ff[127:31]) begin
               counts_in = RELOAD_MAX;
            end else if (sh_ff[30:0] == '0) begin
               counts_in = 32'd1;
            end else begin
               counts_in = sh_ff[31:0];
            end
            done_in  = 1'b1;
            state_in = C_IDLE;
         end
         default: state_in = C_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      delta_ff  <= delta_in;
      pp_ff     <= pp_in;
      acc_ff    <= acc_in;
      sh_ff     <= sh_in;
      counts_ff <= counts_in;
      if (reset) begin
         state_ff <= C_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/core/deadline_timer_sleep_queue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// deadline_timer_sleep_queue: sorted sleep queue with periodic tick
// Chain of queue cells under a request sequencer, with reload conversion.
// ----------------------------------------------------------------------------
// One request at a time. Start and a schedule into a full queue go straight to
// the final result; a schedule inserts its entry and converts a new reload only
// when its deadline is earlier than the armed time, in the multiply/shift/clamp unit.
// Cancel: one cell compared per cycle up to the match, then shift out and reload.
// Timer interrupt: wake each due task in turn, stalling with the result side, then reload.
// Reset clears control, empties the queue and loads register defaults at once.
// ----------------------------------------------------------------------------
module deadline_timer_sleep_queue #(
   parameter int QUEUE_DEPTH  = tsq_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int TASK_ID_BITS = tsq_pkg::TASK_ID_BITS_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   tsq_req_if.sink                                req_ch,
   tsq_rsp_if.source                              rsp_ch,
   input  wire logic                              psel,
   input  wire logic                              penable,
   input  wire logic                              pwrite,
   input  wire logic [tsq_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [tsq_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic      [tsq_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                   pready
);
   import tsq_pkg::*;

   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
   localparam int IDX_BITS = $clog2(QUEUE_DEPTH);

   typedef enum logic [3:0] {
      S_IDLE, S_INS, S_SEEK, S_DROP, S_WAKE, S_RESYNC, S_NEXT, S_CONV, S_FIN
   } state_type;

   cfg_type cfg;

   state_type               state_ff, state_in;
   logic [TASK_ID_BITS-1:0] tid_ff, tid_in;
   logic [TIME_BITS-1:0]    dl_ff, dl_in;
   logic [TIME_BITS-1:0]    now_ff, now_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [CNT_BITS-1:0]     k_ff, k_in;
   logic [TIME_BITS-1:0]    next_tick_ff, next_tick_in;
   logic [TIME_BITS-1:0]    prog_ff, prog_in;
   logic                    fin_rv_ff, fin_rv_in;
   logic [RELOAD_BITS-1:0]  fin_rc_ff, fin_rc_in;
   logic                    fin_te_ff, fin_te_in;
   status_type              fin_st_ff, fin_st_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   kind_type                rsp_kind_ff, rsp_kind_in;
   logic [7:0]              rsp_task_ff, rsp_task_in;
   logic                    rsp_rv_ff, rsp_rv_in;
   logic [RELOAD_BITS-1:0]  rsp_rc_ff, rsp_rc_in;
   logic                    rsp_te_ff, rsp_te_in;
   status_type              rsp_st_ff, rsp_st_in;
   logic                    rsp_last_ff, rsp_last_in;

   cell_cmd_type            cmd;
   logic [IDX_BITS-1:0]     cell_pos;
   logic [TIME_BITS-1:0]    cell_dl [QUEUE_DEPTH];
   logic [TASK_ID_BITS-1:0] cell_tk [QUEUE_DEPTH];
   logic [QUEUE_DEPTH-1:0]  cell_gt;
   logic [QUEUE_DEPTH-1:0]  cell_hit;

   logic                    conv_start;
   logic [TIME_BITS-1:0]    conv_target;
   logic                    conv_done;
   logic [RELOAD_BITS-1:0]  conv_counts;

   logic                    slot_free;
   logic [TIME_BITS-1:0]    ev;
   req_type_type            req_kind;

   tsq_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   for (genvar gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
      logic                    p_gt;
      logic [TIME_BITS-1:0]    p_dl, n_dl;
      logic [TASK_ID_BITS-1:0] p_tk, n_tk;
      if (gi == 0) begin : g_head
         assign p_gt = 1'b0;
         assign p_dl = cell_dl[gi];
         assign p_tk = cell_tk[gi];
      end else begin : g_body
         assign p_gt = cell_gt[gi-1];
         assign p_dl = cell_dl[gi-1];
         assign p_tk = cell_tk[gi-1];
      end
      if (gi == QUEUE_DEPTH - 1) begin : g_tail
         assign n_dl = cell_dl[gi];
         assign n_tk = cell_tk[gi];
      end else begin : g_link
         assign n_dl = cell_dl[gi+1];
         assign n_tk = cell_tk[gi+1];
      end
      tsq_cell #(
         .QUEUE_DEPTH  (QUEUE_DEPTH),
         .TASK_ID_BITS (TASK_ID_BITS),
         .CELL_INDEX   (gi)
      ) u_cell (
         .clock         (clock),
         .cmd           (cmd),
         .cmd_task      (tid_ff),
         .count         (count_ff),
         .pos           (cell_pos),
         .prev_gt       (p_gt),
         .prev_deadline (p_dl),
         .prev_task     (p_tk),
         .next_deadline (n_dl),
         .next_task     (n_tk),
         .gt            (cell_gt[gi]),
         .deadline      (cell_dl[gi]),
         .entry_task    (cell_tk[gi]),
         .hit           (cell_hit[gi])
      );
   end

   tsq_conv u_conv (
      .clock  (clock),
      .reset  (reset),
      .start  (conv_start),
      .target (conv_target),
      .now    (now_ff),
      .mult   (cfg.mult),
      .shift  (cfg.shift),
      .done   (conv_done),
      .counts (conv_counts)
   );

   assign req_ch.ready        = (state_ff == S_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.result_kind  = rsp_kind_ff;
   assign rsp_ch.woken_task   = rsp_task_ff;
   assign rsp_ch.reload_valid = rsp_rv_ff;
   assign rsp_ch.reload_counts = rsp_rc_ff;
   assign rsp_ch.tick_passed  = rsp_te_ff;
   assign rsp_ch.status       = rsp_st_ff;
   assign rsp_ch.last         = rsp_last_ff;

   assign slot_free = !rsp_valid_ff || rsp_ch.ready;
   assign req_kind  = req_type_type'(req_ch.req_type);
   assign ev        = ((count_ff != '0) && (cell_dl[0] < next_tick_ff)) ? cell_dl[0]
                                                                       : next_tick_ff;

   always_comb begin
      state_in     = state_ff;
      tid_in       = tid_ff;
      dl_in        = dl_ff;
      now_in       = now_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      next_tick_in = next_tick_ff;
      prog_in      = prog_ff;
      fin_rv_in    = fin_rv_ff;
      fin_rc_in    = fin_rc_ff;
      fin_te_in    = fin_te_ff;
      fin_st_in    = fin_st_ff;
      cmd.op       = CELL_HOLD;
      cmd.key      = dl_ff;
      cell_pos     = k_ff[IDX_BITS-1:0];
      conv_start   = 1'b0;
      conv_target  = dl_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_task_in  = rsp_task_ff;
      rsp_rv_in    = rsp_rv_ff;
      rsp_rc_in    = rsp_rc_ff;
      rsp_te_in    = rsp_te_ff;
      rsp_st_in    = rsp_st_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               tid_in    = TASK_ID_BITS'(32'(req_ch.task_id));
               dl_in     = req_ch.wake_time;
               now_in    = req_ch.now_ns;
               k_in      = '0;
               fin_rv_in = 1'b0;
               fin_rc_in = '0;
               fin_te_in = 1'b0;
               fin_st_in = ST_OK;
               case (req_kind)
                  REQ_START: begin
                     next_tick_in = req_ch.now_ns + 64'(cfg.period_ns);
                     prog_in      = req_ch.now_ns + 64'(cfg.period_ns);
                     count_in     = '0;
                     fin_rv_in    = 1'b1;
                     fin_rc_in    = cfg.period_counts;
                     state_in     = S_FIN;
                  end
                  REQ_SCHEDULE: begin
                     if (count_ff == CNT_BITS'(QUEUE_DEPTH)) begin
                        fin_st_in = ST_FULL;
                        state_in  = S_FIN;
                     end else begin
                        state_in  = S_INS;
                     end
                  end
                  REQ_CANCEL: state_in = S_SEEK;
                  REQ_TIMER_IRQ: begin
                     if (req_ch.now_ns == '0) begin
                        fin_rv_in = 1'b1;
                        fin_rc_in = cfg.period_counts;
                        fin_te_in = 1'b1;
                        state_in  = S_FIN;
                     end else begin
                        state_in  = S_WAKE;
                     end
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_INS: begin
            cmd.op   = CELL_INSERT;
            count_in = count_ff + 1'b1;
            if (dl_ff < prog_ff) begin
               prog_in    = dl_ff;
               conv_start = 1'b1;
               state_in   = S_CONV;
            end else begin
               state_in   = S_FIN;
            end
         end
         S_SEEK: begin
            if (k_ff >= count_ff) begin
               fin_st_in = ST_NOT_FOUND;
               state_in  = S_FIN;
            end else if (|cell_hit) begin
               state_in  = S_DROP;
            end else begin
               k_in      = k_ff + 1'b1;
            end
         end
         S_DROP: begin
            cmd.op   = CELL_SHIFT;
            count_in = count_ff - 1'b1;
            state_in = S_NEXT;
         end
         S_WAKE: begin
            if ((count_ff != '0) && (cell_dl[0] <= now_ff)) begin
               if (slot_free) begin
                  rsp_valid_in = 1'b1;
                  rsp_kind_in  = KIND_WAKE;
                  rsp_task_in  = 8'(32'(cell_tk[0]));
                  rsp_rv_in    = 1'b0;
                  rsp_rc_in    = '0;
                  rsp_te_in    = 1'b0;
                  rsp_st_in    = ST_OK;
                  rsp_last_in  = 1'b0;
                  cmd.op       = CELL_SHIFT;
                  cell_pos     = '0;
                  count_in     = count_ff - 1'b1;
               end
            end else begin
               fin_te_in = (now_ff >= next_tick_ff);
               if (now_ff >= next_tick_ff) begin
                  next_tick_in = next_tick_ff + 64'(cfg.period_ns);
               end
               state_in = S_RESYNC;
            end
         end
         S_RESYNC: begin
            if (fin_te_ff && (next_tick_ff <= now_ff)) begin
               next_tick_in = now_ff + 64'(cfg.period_ns);
            end
            state_in = S_NEXT;
         end
         S_NEXT: begin
            prog_in     = ev;
            conv_start  = 1'b1;
            conv_target = ev;
            state_in    = S_CONV;
         end
         S_CONV: begin
            if (conv_done) begin
               fin_rv_in = 1'b1;
               fin_rc_in = conv_counts;
               state_in  = S_FIN;
            end
         end
         S_FIN: begin
            if (slot_free) begin
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_FINAL;
               rsp_task_in  = '0;
               rsp_rv_in    = fin_rv_ff;
               rsp_rc_in    = fin_rc_ff;
               rsp_te_in    = fin_te_ff;
               rsp_st_in    = fin_st_ff;
               rsp_last_in  = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      tid_ff      <= tid_in;
      dl_ff       <= dl_in;
      now_ff      <= now_in;
      k_ff        <= k_in;
      fin_rv_ff   <= fin_rv_in;
      fin_rc_ff   <= fin_rc_in;
      fin_te_ff   <= fin_te_in;
      fin_st_ff   <= fin_st_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_task_ff <= rsp_task_in;
      rsp_rv_ff   <= rsp_rv_in;
      rsp_rc_ff   <= rsp_rc_in;
      rsp_te_ff   <= rsp_te_in;
      rsp_st_ff   <= rsp_st_in;
      rsp_last_ff <= rsp_last_in;
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         next_tick_ff <= '0;
         prog_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         next_tick_ff <= next_tick_in;
         prog_ff      <= prog_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule
`default_nettype wire

// ===== tb/deadline_timer_sleep_queue_checker.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_sleep_queue_checker: result predictor and scoreboard
// Watches the request, result and register ports, keeps its own copy of the
// sleep queue, tick and registers, and compares every result transfer with
// the oldest predicted result. Hands the failure count and the number of
// results still due to the testbench top.
// ----------------------------------------------------------------------------
module deadline_timer_sleep_queue_checker #(
   parameter int QUEUE_DEPTH = tsq_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   tsq_req_if                                req_mon,
   tsq_rsp_if                                rsp_mon,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic                              pready,
   input  logic [tsq_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [tsq_pkg::CSR_DATA_BITS-1:0] pwdata,
   output int                                mismatches,
   output int                                outstanding
);
   import tsq_pkg::*;

   typedef struct {
      kind_type    kind;
      logic [7:0]  woken;
      logic        reload_valid;
      logic [31:0] reload_counts;
      logic        tick_passed;
      status_type  status;
      logic        last;
   } timer_result_type;

   timer_result_type due_results[$];

   logic [29:0] period_ns;
   logic [31:0] period_counts;
   logic [63:0] mult;
   logic [5:0]  shift;

   logic [63:0] entry_deadline[QUEUE_DEPTH];
   logic [7:0]  entry_task[QUEUE_DEPTH];
   int          entry_count;
   logic [63:0] next_tick;
   logic [63:0] armed_time;
   int          fail_count;

   initial fail_count = 0;

   function automatic logic [31:0] ns_to_counts(input logic [63:0] target,
                                                input logic [63:0] now);
      logic [63:0]  delta;
      logic [127:0] product;
      delta   = (target > now) ? target - now : 64'd0;
      product = ({64'd0, delta} * {64'd0, mult}) >> shift;
      if (product > {96'd0, RELOAD_MAX}) return RELOAD_MAX;
      if (product == 128'd0) return 32'd1;
      return product[31:0];
   endfunction

   // earliest of tick and queue head becomes the armed one-shot time
   function automatic logic [31:0] rearm(input logic [63:0] now);
      logic [63:0] soonest;
      soonest = next_tick;
      if (entry_count > 0 && entry_deadline[0] < soonest) soonest = entry_deadline[0];
      armed_time = soonest;
      return ns_to_counts(soonest, now);
   endfunction

   function automatic void drop_entry(input int pos);
      int i;
      for (i = pos; i + 1 < entry_count; i++) begin
         entry_deadline[i] = entry_deadline[i+1];
         entry_task[i]     = entry_task[i+1];
      end
      entry_count--;
   endfunction

   function automatic void expect_result(input kind_type kind, input logic [7:0] woken,
                                         input logic rv, input logic [31:0] rc,
                                         input logic te, input status_type st,
                                         input logic last);
      due_results.push_back('{kind, woken, rv, rc, te, st, last});
   endfunction

   function automatic void sleep_queue_step(input req_type_type op, input logic [7:0] id,
                                            input logic [63:0] deadline,
                                            input logic [63:0] now);
      int          pos;
      int          i;
      logic        expired;
      logic [31:0] counts;
      case (op)
         REQ_START: begin
            next_tick   = now + 64'(period_ns);
            armed_time  = next_tick;
            entry_count = 0;
            expect_result(KIND_FINAL, 8'd0, 1'b1, period_counts, 1'b0, ST_OK, 1'b1);
         end
         REQ_SCHEDULE: begin
            if (entry_count >= QUEUE_DEPTH) begin
               expect_result(KIND_FINAL, 8'd0, 1'b0, 32'd0, 1'b0, ST_FULL, 1'b1);
            end else begin
               pos = 0;
               while (pos < entry_count && entry_deadline[pos] <= deadline) pos++;
               for (i = entry_count; i > pos; i--) begin
                  entry_deadline[i] = entry_deadline[i-1];
                  entry_task[i]     = entry_task[i-1];
               end
               entry_deadline[pos] = deadline;
               entry_task[pos]     = id;
               entry_count++;
               if (deadline < armed_time) begin
                  armed_time = deadline;
                  counts     = ns_to_counts(deadline, now);
                  expect_result(KIND_FINAL, 8'd0, 1'b1, counts, 1'b0, ST_OK, 1'b1);
               end else begin
                  expect_result(KIND_FINAL, 8'd0, 1'b0, 32'd0, 1'b0, ST_OK, 1'b1);
               end
            end
         end
         REQ_CANCEL: begin
            pos = 0;
            while (pos < entry_count && entry_task[pos] != id) pos++;
            if (pos == entry_count) begin
               expect_result(KIND_FINAL, 8'd0, 1'b0, 32'd0, 1'b0, ST_NOT_FOUND, 1'b1);
            end else begin
               drop_entry(pos);
               counts = rearm(now);
               expect_result(KIND_FINAL, 8'd0, 1'b1, counts, 1'b0, ST_OK, 1'b1);
            end
         end
         REQ_TIMER_IRQ: begin
            if (now == 64'd0) begin
               expect_result(KIND_FINAL, 8'd0, 1'b1, period_counts, 1'b1, ST_OK, 1'b1);
            end else begin
               while (entry_count > 0 && entry_deadline[0] <= now) begin
                  expect_result(KIND_WAKE, entry_task[0], 1'b0, 32'd0, 1'b0, ST_OK, 1'b0);
                  drop_entry(0);
               end
               expired = (now >= next_tick);
               if (expired) begin
                  next_tick = next_tick + 64'(period_ns);
                  if (next_tick <= now) next_tick = now + 64'(period_ns);
               end
               counts = rearm(now);
               expect_result(KIND_FINAL, 8'd0, 1'b1, counts, expired, ST_OK, 1'b1);
            end
         end
         default: ;
      endcase
   endfunction

   always @(posedge clock) begin
      timer_result_type want;
      if (reset) begin
         period_ns     = PERIOD_NS_RESET;
         period_counts = PERIOD_COUNTS_RESET;
         mult          = 64'd0;
         shift         = 6'd0;
         entry_count   = 0;
         next_tick     = 64'd0;
         armed_time    = 64'd0;
         due_results.delete();
      end else begin
         if (psel && penable && pwrite && pready) begin
            case (csr_index_type'(paddr[4:3]))
               CSR_PERIOD_NS:     period_ns     = pwdata[29:0];
               CSR_PERIOD_COUNTS: period_counts = pwdata[31:0];
               CSR_MULT:          mult          = pwdata;
               CSR_SHIFT:         shift         = pwdata[5:0];
               default: ;
            endcase
         end
         if (req_mon.valid && req_mon.ready) begin
            sleep_queue_step(req_type_type'(req_mon.req_type), req_mon.task_id,
                             req_mon.wake_time, req_mon.now_ns);
         end
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (due_results.size() == 0) begin
               if (fail_count < 10) begin
                  $display("unexpected result transfer: kind %0d task %0d reload %0d/%0d",
                           rsp_mon.result_kind, rsp_mon.woken_task, rsp_mon.reload_valid,
                           rsp_mon.reload_counts);
               end
               fail_count++;
            end else begin
               want = due_results[0];
               due_results.delete(0);
               if (rsp_mon.result_kind !== want.kind || rsp_mon.woken_task !== want.woken ||
                   rsp_mon.reload_valid !== want.reload_valid ||
                   rsp_mon.reload_counts !== want.reload_counts ||
                   rsp_mon.tick_passed !== want.tick_passed ||
                   rsp_mon.status !== want.status || rsp_mon.last !== want.last) begin
                  if (fail_count < 10) begin
                     $display("result mismatch: expected kind %0d task %0d reload %0d/%0d",
                              want.kind, want.woken, want.reload_valid, want.reload_counts,
                              " tick %0d status %0d last %0d",
                              want.tick_passed, want.status, want.last);
                     $display("                 actual   kind %0d task %0d reload %0d/%0d",
                              rsp_mon.result_kind, rsp_mon.woken_task,
                              rsp_mon.reload_valid, rsp_mon.reload_counts,
                              " tick %0d status %0d last %0d",
                              rsp_mon.tick_passed, rsp_mon.status, rsp_mon.last);
                  end
                  fail_count++;
               end
            end
         end
      end
      mismatches  <= fail_count;
      outstanding <= due_results.size();
   end

endmodule

// ===== tb/deadline_timer_sleep_queue_tb.sv =====
// ----------------------------------------------------------------------------
// deadline_timer_sleep_queue_tb: testbench top of the sleep queue timer
// Drives directed and random requests in bursts under several register
// settings, stalls the result side on changing patterns, and reports the
// verdict from the checker's failure and outstanding-result counts.
// ----------------------------------------------------------------------------
module deadline_timer_sleep_queue_tb;
   import tsq_pkg::*;

   localparam int CYCLE_LIMIT  = 800000;
   localparam int LONG_HOLD    = 400;
   localparam int SETTLE       = 40;
   localparam int PHASE_ITEMS  = 60;

   typedef enum int {RX_STEADY, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   logic                     clock = 1'b0;
   logic                     reset;
   logic                     psel;
   logic                     penable;
   logic                     pwrite;
   logic                     pready;
   logic [CSR_ADDR_BITS-1:0] paddr;
   logic [CSR_DATA_BITS-1:0] pwdata;
   logic [CSR_DATA_BITS-1:0] prdata;

   int          mismatches;
   int          outstanding;
   int          hold_requests;
   int          cycle_count;
   int          burst_left;
   logic [63:0] clock_ns;
   logic [63:0] cur_period;
   logic [63:0] last_deadline;

   tsq_req_if req_ch();
   tsq_rsp_if rsp_ch();

   deadline_timer_sleep_queue u_top (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   deadline_timer_sleep_queue_checker u_checker (
      .clock       (clock),
      .reset       (reset),
      .req_mon     (req_ch),
      .rsp_mon     (rsp_ch),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .pready      (pready),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   always #4 clock = ~clock;

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   // result side: changing stall pattern, plus long hold-offs on request
   initial begin
      rx_mode_type mode;
      int          mode_left;
      int          hold_left;
      int          hold_served;
      rsp_ch.ready = 1'b0;
      mode         = RX_STEADY;
      mode_left    = 0;
      hold_left    = 0;
      hold_served  = 0;
      forever begin
         @(posedge clock);
         if (mode_left == 0) begin
            mode      = rx_mode_type'($urandom_range(0, 3));
            mode_left = $urandom_range(40, 300);
         end else begin
            mode_left--;
         end
         if (hold_served != hold_requests) begin
            hold_served = hold_requests;
            hold_left   = LONG_HOLD;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            case (mode)
               RX_STEADY: rsp_ch.ready <= 1'b1;
               RX_COIN:   rsp_ch.ready <= 1'($urandom_range(0, 1));
               RX_SPARSE: rsp_ch.ready <= ($urandom_range(0, 3) == 0);
               default:   rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   task automatic send_req(input req_type_type op, input logic [7:0] id,
                           input logic [63:0] deadline, input logic [63:0] now);
      if (burst_left == 0) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
      end
      req_ch.valid     <= 1'b1;
      req_ch.req_type  <= op;
      req_ch.task_id   <= id;
      req_ch.wake_time <= deadline;
      req_ch.now_ns    <= now;
      do @(posedge clock); while (!req_ch.ready);
      burst_left--;
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [63:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {idx, 3'b000};
      pwdata  <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      if (idx == CSR_PERIOD_NS) cur_period = {34'd0, value[29:0]};
   endtask

   task automatic configure(input logic [63:0] pn, input logic [63:0] pc,
                            input logic [63:0] m, input logic [63:0] s);
      drain();
      csr_write(CSR_PERIOD_NS, pn);
      csr_write(CSR_PERIOD_COUNTS, pc);
      csr_write(CSR_MULT, m);
      csr_write(CSR_SHIFT, s);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic run_directed();
      logic [63:0] t0;
      logic [63:0] deadline;
      logic [7:0]  id;
      int          i;
      t0 = 64'd5_000_000;
      send_req(REQ_START, 8'd0, 64'd0, t0);
      for (i = 0; i < 16; i++) begin
         id = (i == 9) ? 8'd34 : 8'(i * 17);
         case (i)
            0:       deadline = 64'd0;
            1:       deadline = '1;
            2, 3:    deadline = t0 + 64'd500_000;
            9:       deadline = t0 + 64'd200_000;
            default: deadline = t0 + 64'(i * 100_000);
         endcase
         send_req(REQ_SCHEDULE, id, deadline, t0);
      end
      send_req(REQ_SCHEDULE, 8'd200, t0 + 64'd1, t0);
      send_req(REQ_CANCEL, 8'd99, 64'd0, t0);
      send_req(REQ_CANCEL, 8'd34, 64'd0, t0);
      send_req(REQ_TIMER_IRQ, 8'd0, 64'd0, 64'd0);
      send_req(REQ_TIMER_IRQ, 8'd0, 64'd0, t0 + 64'd700_000);
      send_req(REQ_TIMER_IRQ, 8'd0, 64'd0, '1);
      send_req(REQ_START, 8'd0, 64'd0, '1);
      send_req(REQ_TIMER_IRQ, 8'd0, 64'd0, 64'd3);
      clock_ns = 64'd10_000_000;
   endtask

   task automatic random_item();
      int          pick;
      logic [7:0]  id;
      logic [63:0] deadline;
      logic [63:0] now;
      pick     = $urandom_range(0, 99);
      id       = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                             : 8'($urandom_range(0, 15));
      deadline = rand64();
      now      = clock_ns;
      if (pick < 4) begin
         send_req(REQ_START, id, deadline, now);
      end else if (pick < 50) begin
         case ($urandom_range(0, 9))
            0:       deadline = last_deadline;
            1:       deadline = rand64();
            2:       deadline = clock_ns - rand64() % (cur_period + 64'd1);
            default: deadline = clock_ns + rand64() % (64'd3 * cur_period + 64'd1);
         endcase
         last_deadline = deadline;
         send_req(REQ_SCHEDULE, id, deadline, now);
      end else if (pick < 65) begin
         send_req(REQ_CANCEL, id, deadline, now);
      end else if (pick < 95) begin
         clock_ns = clock_ns + rand64() % (64'd2 * cur_period + 64'd1);
         now      = clock_ns;
         if ($urandom_range(0, 19) == 0) now = 64'd0;
         else if ($urandom_range(0, 29) == 0) now = rand64();
         send_req(REQ_TIMER_IRQ, id, deadline, now);
      end else begin
         send_req(req_type_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  rand64(), rand64());
      end
   endtask

   task automatic random_phase(input int count, input logic pressure);
      int k;
      send_req(REQ_START, 8'd0, 64'd0, clock_ns);
      for (k = 0; k < count; k++) begin
         if (pressure && k == count / 3) drain();
         if (pressure && k == count / 2) hold_requests <= hold_requests + 1;
         random_item();
      end
   endtask

   initial begin
      reset              = 1'b1;
      psel               = 1'b0;
      penable            = 1'b0;
      pwrite             = 1'b0;
      paddr              = '0;
      pwdata             = '0;
      req_ch.valid       = 1'b0;
      req_ch.req_type    = REQ_START;
      req_ch.task_id     = 8'd0;
      req_ch.wake_time   = 64'd0;
      req_ch.now_ns      = 64'd0;
      hold_requests      = 0;
      burst_left         = 0;
      clock_ns           = 64'd0;
      cur_period         = 64'(PERIOD_NS_RESET);
      last_deadline      = 64'd0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      configure(64'd1_000_000, 64'd62_500, 64'h1000_0000, 64'd32);
      run_directed();
      random_phase(PHASE_ITEMS, 1'b1);
      configure(64'd1, 64'hFFFF_FFFF, '1, 64'd0);
      random_phase(PHASE_ITEMS, 1'b0);
      configure(64'd1_000_000_000, 64'd1, 64'd1, 64'd63);
      random_phase(PHASE_ITEMS, 1'b0);
      configure(64'($urandom_range(1, 1_000_000_000)), 64'($urandom_range(1, 32'hFFFF_FFFF)),
                rand64(), 64'($urandom_range(0, 63)));
      random_phase(PHASE_ITEMS, 1'b1);
      configure(64'd1000, 64'd16, 64'h4_0000_0000, 64'd34);
      random_phase(PHASE_ITEMS, 1'b0);

      drain();
      repeat (SETTLE) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/core/tsq_pkg.sv
rtl/core/tsq_req_if.sv
rtl/core/tsq_rsp_if.sv
rtl/core/tsq_csr.sv
rtl/core/tsq_cell.sv
rtl/core/tsq_conv.sv
rtl/core/deadline_timer_sleep_queue.sv
tb/deadline_timer_sleep_queue_checker.sv
tb/deadline_timer_sleep_queue_tb.sv
